>>> rtl/stlt_pkg.sv
package stlt_pkg;

	localparam int TOKEN_W   = 256;
	localparam int TIME_W    = 48;
	localparam int TIMEOUT_W = 40;
	localparam int INDEX_W   = 3;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 40'd1800000000;

	typedef enum logic [1:0] {
		OP_CREATE     = 2'd0,
		OP_VALIDATE   = 2'd1,
		OP_INVALIDATE = 2'd2,
		OP_CLEAR_ALL  = 2'd3
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [TOKEN_W-1:0] token;
		logic [TIME_W-1:0]  now;
	} req_t;

endpackage

>>> rtl/stlt_front.sv
module stlt_front
	import stlt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        cmd,
	input  logic [63:0]       token_word0,
	input  logic [63:0]       token_word1,
	input  logic [63:0]       token_word2,
	input  logic [63:0]       token_word3,
	input  logic [TIME_W-1:0] now_us,
	output logic              busy,
	output logic              req_valid,
	output req_t              req,
	input  logic              req_pop
);

	// two-entry queue between command intake and the slot engine
	logic [1:0] cnt_q;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	req_t       fifo_q [2];
	logic       push;
	logic       pop;
	req_t       entry;

	assign busy      = (cnt_q == 2'd2);
	assign push      = start && !busy;
	assign pop       = req_pop && req_valid;
	assign req_valid = (cnt_q != 2'd0);
	assign req       = fifo_q[rd_ptr_q];

	always_comb begin
		entry.op    = op_t'(cmd);
		entry.token = {token_word3, token_word2, token_word1, token_word0};
		entry.now   = now_us;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= entry;
		end
	end

endmodule

>>> rtl/stlt_back.sv
module stlt_back
	import stlt_pkg::*;
#(
	parameter int SLOTS = 8
)
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  req_t                 req,
	output logic                 req_pop,
	input  logic [TIMEOUT_W-1:0] timeout,
	output logic                 done,
	output logic                 ok,
	output logic [INDEX_W-1:0]   slot_index,
	output logic                 evicted,
	output logic                 expired
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam int XW = IW + INDEX_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_EVAL
	} state_t;

	state_t              state_q;
	req_t                cur_q;
	logic [CW-1:0]       issue_cnt_q;
	logic                rd_vld_q;
	logic [IW-1:0]       rd_idx_q;
	logic [TOKEN_W-1:0]  tok_rd_q;
	logic [TIME_W-1:0]   seen_rd_q;
	logic [SLOTS-1:0]    active_q;
	logic                found_q;
	logic [IW-1:0]       match_idx_q;
	logic [TIME_W-1:0]   match_seen_q;
	logic                free_found_q;
	logic [IW-1:0]       free_idx_q;
	logic [TIME_W-1:0]   min_seen_q;
	logic [IW-1:0]       min_idx_q;
	logic                done_q;
	logic                ok_q;
	logic [INDEX_W-1:0]  slot_index_q;
	logic                evicted_q;
	logic                expired_q;

	logic [TOKEN_W-1:0]  tok_mem  [SLOTS];
	logic [TIME_W-1:0]   seen_mem [SLOTS];

	logic [IW-1:0]       rd_addr;
	logic                scan_end;
	logic                rd_act;
	logic [TIME_W:0]     idle_diff;
	logic                is_stale;
	logic [IW-1:0]       create_idx;
	logic [IW-1:0]       eval_idx;
	logic [XW-1:0]       eval_idx_ext;
	logic                tok_we;
	logic                seen_we;

	assign rd_addr      = issue_cnt_q[IW-1:0];
	assign scan_end     = (issue_cnt_q == CW'(SLOTS)) && !rd_vld_q;
	assign rd_act       = active_q[rd_idx_q];
	assign req_pop      = (state_q == S_IDLE) && req_valid;
	assign idle_diff    = {1'b0, cur_q.now} - {1'b0, match_seen_q};
	assign is_stale     = !idle_diff[TIME_W] &&
		(idle_diff[TIME_W-1:0] > {{(TIME_W-TIMEOUT_W){1'b0}}, timeout});
	assign create_idx   = free_found_q ? free_idx_q : min_idx_q;
	assign eval_idx     = (cur_q.op == OP_CREATE) ? create_idx : match_idx_q;
	assign eval_idx_ext = XW'(eval_idx);

	always_comb begin
		tok_we  = 1'b0;
		seen_we = 1'b0;
		if (state_q == S_EVAL) begin
			case (cur_q.op)
				OP_CREATE: begin
					tok_we  = 1'b1;
					seen_we = 1'b1;
				end
				OP_VALIDATE: begin
					seen_we = found_q && !is_stale;
				end
				default: begin
					seen_we = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		tok_rd_q  <= tok_mem[rd_addr];
		seen_rd_q <= seen_mem[rd_addr];
		if (tok_we) begin
			tok_mem[eval_idx] <= cur_q.token;
		end
		if (seen_we) begin
			seen_mem[eval_idx] <= cur_q.now;
		end
	end

	// payload registers without reset
	always_ff @(posedge clk) begin
		if (req_pop) begin
			cur_q <= req;
		end
		if (state_q == S_SCAN && rd_vld_q) begin
			if (!rd_act && !free_found_q) begin
				free_idx_q <= rd_idx_q;
			end
			if (rd_act && !found_q && tok_rd_q == cur_q.token) begin
				match_idx_q  <= rd_idx_q;
				match_seen_q <= seen_rd_q;
			end
			if (rd_idx_q == '0 || seen_rd_q < min_seen_q) begin
				min_seen_q <= seen_rd_q;
				min_idx_q  <= rd_idx_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			issue_cnt_q  <= '0;
			rd_vld_q     <= 1'b0;
			rd_idx_q     <= '0;
			active_q     <= '0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			done_q       <= 1'b0;
			ok_q         <= 1'b0;
			slot_index_q <= '0;
			evicted_q    <= 1'b0;
			expired_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						if (req.op == OP_CLEAR_ALL) begin
							done_q       <= 1'b1;
							ok_q         <= |active_q;
							slot_index_q <= '0;
							evicted_q    <= 1'b0;
							expired_q    <= 1'b0;
							active_q     <= '0;
						end else begin
							state_q      <= S_SCAN;
							issue_cnt_q  <= '0;
							rd_vld_q     <= 1'b0;
							found_q      <= 1'b0;
							free_found_q <= 1'b0;
						end
					end
				end
				S_SCAN: begin
					if (issue_cnt_q != CW'(SLOTS)) begin
						rd_vld_q    <= 1'b1;
						rd_idx_q    <= rd_addr;
						issue_cnt_q <= issue_cnt_q + CW'(1);
					end else begin
						rd_vld_q <= 1'b0;
					end
					if (rd_vld_q) begin
						if (!rd_act) begin
							free_found_q <= 1'b1;
						end
						if (rd_act && tok_rd_q == cur_q.token) begin
							found_q <= 1'b1;
						end
					end
					if (scan_end) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					state_q      <= S_IDLE;
					done_q       <= 1'b1;
					ok_q         <= 1'b0;
					slot_index_q <= '0;
					evicted_q    <= 1'b0;
					expired_q    <= 1'b0;
					case (cur_q.op)
						OP_CREATE: begin
							ok_q               <= 1'b1;
							evicted_q          <= !free_found_q;
							slot_index_q       <= eval_idx_ext[INDEX_W-1:0];
							active_q[eval_idx] <= 1'b1;
						end
						OP_VALIDATE: begin
							if (found_q) begin
								slot_index_q <= eval_idx_ext[INDEX_W-1:0];
								if (is_stale) begin
									expired_q          <= 1'b1;
									active_q[eval_idx] <= 1'b0;
								end else begin
									ok_q <= 1'b1;
								end
							end
						end
						OP_INVALIDATE: begin
							if (found_q) begin
								ok_q               <= 1'b1;
								slot_index_q       <= eval_idx_ext[INDEX_W-1:0];
								active_q[eval_idx] <= 1'b0;
							end
						end
						default: begin
							ok_q <= 1'b0;
						end
					endcase
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done       = done_q;
	assign ok         = ok_q;
	assign slot_index = slot_index_q;
	assign evicted    = evicted_q;
	assign expired    = expired_q;

endmodule

>>> rtl/session_table_lru_timeout_top.sv
// Session table with SLOTS slots of 256-bit tokens, least-recently-seen eviction on
// create and an idle timeout checked on validate. A command is taken when start is
// high and busy is low; busy rises only when the two-entry command queue is full, so
// up to two commands can wait while one is worked on. For create, validate and
// invalidate the slot engine reads the token and last-seen memories one slot per
// cycle through a single registered read port, then applies the update in its eval
// state. Invalidate-all is applied straight from idle, with no scan. Results come
// back in command order, one per command, each shown for a single cycle with done high;
// the receiver cannot stall them. The idle timeout register is written through
// cfg_valid and cfg_ready, which is always high; write it only while no command is
// pending. After reset every slot is inactive and no clearing pass is needed.
module session_table_lru_timeout_top
	import stlt_pkg::*;
#(
	parameter int SLOTS = 8
)
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           cmd,
	input  logic [63:0]          token_word0,
	input  logic [63:0]          token_word1,
	input  logic [63:0]          token_word2,
	input  logic [63:0]          token_word3,
	input  logic [TIME_W-1:0]    now_us,
	output logic                 done,
	output logic                 ok,
	output logic [INDEX_W-1:0]   slot_index,
	output logic                 evicted,
	output logic                 expired,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [TIMEOUT_W-1:0] cfg_data
);

	logic                 req_valid;
	logic                 req_pop;
	req_t                 req;
	logic [TIMEOUT_W-1:0] timeout_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			timeout_q <= cfg_data;
		end
	end

	stlt_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.cmd         (cmd),
		.token_word0 (token_word0),
		.token_word1 (token_word1),
		.token_word2 (token_word2),
		.token_word3 (token_word3),
		.now_us      (now_us),
		.busy        (busy),
		.req_valid   (req_valid),
		.req         (req),
		.req_pop     (req_pop)
	);

	stlt_back #(
		.SLOTS (SLOTS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req        (req),
		.req_pop    (req_pop),
		.timeout    (timeout_q),
		.done       (done),
		.ok         (ok),
		.slot_index (slot_index),
		.evicted    (evicted),
		.expired    (expired)
	);

endmodule

>>> rtl/stlt_checker.sv
module stlt_checker
	import stlt_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic               ok,
	input logic [INDEX_W-1:0] slot_index,
	input logic               evicted,
	input logic               expired
);

	// eviction only happens on a successful create
	a_evict_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && evicted |-> ok)
		else $error("eviction reported without success");

	a_expire_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done && expired |-> !ok && !evicted)
		else $error("expiry reported together with success or eviction");

	// a failed result without expiry carries no slot
	a_miss_index: assert property (@(posedge clk) disable iff (!arst_n)
		done && !ok && !expired |-> slot_index == '0)
		else $error("slot index set on a result without a slot");

	// the queue only fills through a transfer
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a command transfer");

endmodule

bind session_table_lru_timeout_top stlt_checker u_stlt_checker (.*);
